/* rtl/rtp_pkg.sv */
// Shared types, constants and power-of-ten table for the rational text parser.
`timescale 1ns / 1ps
package rtp_pkg;

   // magnitude width: every value must stay at or below 2^(VALUE_BITS-1)-1
   localparam int VALUE_BITS = 64;
   localparam int VW         = VALUE_BITS - 1;
   localparam logic [VW-1:0] MAXV = '1;

   // multiplier: one CW-bit slice of the multiplier per cycle
   localparam int CW    = 16;
   localparam int NCH   = (VW + CW - 1) / CW;
   localparam int CNT_W = $clog2(NCH + 1);

   // digit counters saturate
   localparam int DCNT_W = 5;
   localparam logic [DCNT_W-1:0] DCNT_MAX = '1;

   // largest exponent present in the power-of-ten table
   localparam int POW_MAX = 19;

   // ASCII codes
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_RPAR  = 8'h29;
   localparam logic [7:0] CH_E_LO  = 8'h65;
   localparam logic [7:0] CH_E_UP  = 8'h45;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   typedef enum logic [3:0] {
      ST_SKIP, ST_INT, ST_DEN, ST_MIXN, ST_MIXD, ST_FRACT, ST_PER, ST_PEREND,
      ST_EXPS, ST_EXPD, ST_ERR, ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4, ST_CAP
   } state_type;

   typedef enum logic [1:0] {ACC_NONE, ACC_FIRST, ACC_SECOND, ACC_THIRD} acc_sel_type;

   typedef enum logic [2:0] {
      MUL_NONE, MUL_FIRST, MUL_PER_NUM, MUL_PER_DEN, MUL_EXP
   } mul_op_type;

   typedef enum logic [2:0] {
      FORM_NONE, FORM_INTEGER, FORM_FRACTION, FORM_MIXED,
      FORM_DECIMAL, FORM_PERIODIC, FORM_EXPONENT
   } form_type;

   typedef enum logic [1:0] {
      STAT_OK, STAT_MALFORMED, STAT_MIXED, STAT_OVERFLOW
   } status_type;

   // controller to datapath
   typedef struct packed {
      acc_sel_type acc_sel;
      logic        inc_frac;
      logic        inc_per;
      mul_op_type  mul_op;
      logic        mul_start;
      logic        exp_neg;
      logic        capture;
      form_type    form;
      logic        negative;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic mul_busy;
      logic mul_done;
   } dp_stat_type;

   function automatic logic [63:0] pow10(input logic [4:0] n);
      logic [63:0] r;
      case (n)
         5'd0:    r = 64'd1;
         5'd1:    r = 64'd10;
         5'd2:    r = 64'd100;
         5'd3:    r = 64'd1000;
         5'd4:    r = 64'd10000;
         5'd5:    r = 64'd100000;
         5'd6:    r = 64'd1000000;
         5'd7:    r = 64'd10000000;
         5'd8:    r = 64'd100000000;
         5'd9:    r = 64'd1000000000;
         5'd10:   r = 64'd10000000000;
         5'd11:   r = 64'd100000000000;
         5'd12:   r = 64'd1000000000000;
         5'd13:   r = 64'd10000000000000;
         5'd14:   r = 64'd100000000000000;
         5'd15:   r = 64'd1000000000000000;
         5'd16:   r = 64'd10000000000000000;
         5'd17:   r = 64'd100000000000000000;
         5'd18:   r = 64'd1000000000000000000;
         5'd19:   r = 64'd10000000000000000000;
         default: r = 64'd0;
      endcase
      return r;
   endfunction

   // 10^n does not fit under the magnitude limit
   function automatic logic pow10_ovf(input logic [VW-1:0] n);
      logic big;
      big = (n > VW'(POW_MAX));
      return big || (pow10(n[4:0]) > 64'(MAXV));
   endfunction

   function automatic logic [VW-1:0] pow10_val(input logic [VW-1:0] n);
      return VW'(pow10(n[4:0]));
   endfunction

endpackage

/* rtl/rational_text_parser.sv */
// Top level of the rational text parser: controller, datapath and checks.
`timescale 1ns / 1ps
// Usage:
//  The req channel carries the text of a number, one ASCII character per
//  transaction; req_tlast marks the final character. One result transaction
//  follows each text on the rsp channel: signed numerator and denominator in
//  rsp_tdata, form and status in rsp_tuser.
//  Characters are taken one per cycle while the parser reads text.
//  After the final character req_tready drops while the fraction is built:
//   integer, fraction or malformed text: no multiply, straight to capture;
//   mixed and decimal: one checked multiply;
//   periodic: three multiplies; exponent: two.
//  Each multiply is the iterative multiplier taking a 16-bit slice of the
//  multiplier per cycle, then a step that adds the addend, with a start step
//  before it and a handoff step after it.
//  The result sits in an output register; the next text may stream in while
//  it waits. If the receiver is still stalled when the following result is
//  ready, the parser holds in its final state with req_tready low.
//  Synchronous reset returns the parser to leading-space skipping with all
//  accumulators cleared and no result pending.
module rational_text_parser (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,  // [7:0] ch
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,  // [63:0] numerator, [126:64] denominator, [127] zero
   output logic [4:0]   rsp_tuser   // [2:0] form, [4:3] status
);
   rtp_pkg::dp_cmd_type  cmd;
   rtp_pkg::dp_stat_type stat;
   logic [63:0]          rsp_num;
   logic [62:0]          rsp_den;
   logic [2:0]           rsp_form;
   logic [1:0]           rsp_status;

   rtp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_ch     (req_tdata),
      .req_last   (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   rtp_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .ch         (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_num    (rsp_num),
      .rsp_den    (rsp_den),
      .rsp_form   (rsp_form),
      .rsp_status (rsp_status)
   );

   assign rsp_tdata = {1'b0, rsp_den, rsp_num};
   assign rsp_tuser = {rsp_status, rsp_form};

   // final character starts the build: no new text is taken next cycle
   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("text accepted right after final character");

   // any error gives the zero result
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status != rtp_pkg::STAT_OK |-> rsp_num == 64'd0 && rsp_den == 63'd1)
      else $error("error result is not 0/1");

   // malformed text carries no form
   a_malformed_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status == rtp_pkg::STAT_MALFORMED |-> rsp_form == rtp_pkg::FORM_NONE)
      else $error("malformed result with a form");

   // denominator never zero
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_den != 63'd0)
      else $error("zero denominator");

endmodule

/* rtl/rtp_mul.sv */
// Iterative checked multiply-add: prod = a*b + c, one slice of b per cycle.
`timescale 1ns / 1ps
module rtp_mul (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [rtp_pkg::VW-1:0] a,
   input  logic [rtp_pkg::VW-1:0] b,
   input  logic [rtp_pkg::VW-1:0] c,
   output logic                   busy,
   output logic                   done,
   output logic [rtp_pkg::VW-1:0] prod,
   output logic                   ovf
);
   localparam int VW = rtp_pkg::VW;
   localparam int CW = rtp_pkg::CW;
   localparam int AW = VW + CW + 1;
   localparam int BW = rtp_pkg::NCH * CW;

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [rtp_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic [AW-1:0]                   acc_ff, acc_in;
   logic [VW-1:0]                   a_ff, a_in;
   logic [BW-1:0]                   b_ff, b_in;
   logic [VW-1:0]                   c_ff, c_in;
   logic                            ovf_ff, ovf_in;
   logic [VW-1:0]                   prod_ff, prod_in;
   logic [VW+CW-1:0]                part;
   logic [AW-1:0]                   acc_next;
   logic [VW:0]                     sum;

   // partial product of the top slice, accumulated most significant first
   assign part     = a_ff * b_ff[BW-1 -: CW];
   assign acc_next = {acc_ff[AW-CW-1:0], {CW{1'b0}}} + AW'(part);
   assign sum      = {1'b0, acc_ff[VW-1:0]} + {1'b0, c_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      c_in    = c_ff;
      ovf_in  = ovf_ff;
      prod_in = prod_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = rtp_pkg::CNT_W'(rtp_pkg::NCH);
         acc_in  = '0;
         a_in    = a;
         b_in    = BW'(b);
         c_in    = c;
         ovf_in  = 1'b0;
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            acc_in = acc_next;
            ovf_in = ovf_ff | (|acc_next[AW-1:VW]);
            b_in   = b_ff << CW;
            cnt_in = cnt_ff - 1'b1;
         end else begin
            // final cycle adds the addend
            prod_in = sum[VW-1:0];
            ovf_in  = ovf_ff | sum[VW];
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      c_ff    <= c_in;
      ovf_ff  <= ovf_in;
      prod_ff <= prod_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign prod = prod_ff;
   assign ovf  = ovf_ff;

endmodule

/* rtl/rtp_dp.sv */
// Datapath: digit accumulators, final multiplies and the result register.
`timescale 1ns / 1ps
module rtp_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           ch,
   input  rtp_pkg::dp_cmd_type  cmd,
   output rtp_pkg::dp_stat_type stat,
   output logic [63:0]          rsp_num,
   output logic [62:0]          rsp_den,
   output logic [2:0]           rsp_form,
   output logic [1:0]           rsp_status
);
   localparam int VW = rtp_pkg::VW;
   localparam int DW = rtp_pkg::DCNT_W;

   logic [VW-1:0]     first_ff, first_in;
   logic [VW-1:0]     second_ff, second_in;
   logic [VW-1:0]     third_ff, third_in;
   logic [DW-1:0]     frac_ff, frac_in;
   logic [DW-1:0]     per_ff, per_in;
   logic              ovf_ff, ovf_in;
   logic [VW-1:0]     num_ff, num_in;
   logic [VW-1:0]     den_ff, den_in;
   logic [63:0]       onum_ff, onum_in;
   logic [62:0]       oden_ff, oden_in;
   logic [2:0]        oform_ff, oform_in;
   logic [1:0]        ostat_ff, ostat_in;

   logic [VW-1:0]     acc_src;
   logic [VW+3:0]     acc_ten;
   logic              acc_ovf;
   logic [VW-1:0]     mul_a, mul_b, mul_c;
   logic              pow_ovf;
   logic [VW-1:0]     per_f;
   logic              per_f_ovf;
   logic              mul_busy, mul_done, mul_ovf;
   logic [VW-1:0]     mul_prod;
   logic [VW-1:0]     cap_mag, cap_den;
   rtp_pkg::status_type cap_stat;

   // digit accumulate: v*10 + d with limit check
   always_comb begin
      unique case (cmd.acc_sel)
         rtp_pkg::ACC_FIRST:  acc_src = first_ff;
         rtp_pkg::ACC_SECOND: acc_src = second_ff;
         rtp_pkg::ACC_THIRD:  acc_src = third_ff;
         default:             acc_src = '0;
      endcase
   end

   assign acc_ten = (VW+4)'({acc_src, 3'b000}) + (VW+4)'({acc_src, 1'b0}) + (VW+4)'(ch[3:0]);
   assign acc_ovf = (acc_ten > (VW+4)'(rtp_pkg::MAXV));

   // period factor 10^p - 1, or 1 for empty parentheses
   assign per_f = (per_ff == '0) ? VW'(1) : rtp_pkg::pow10_val(VW'(per_ff)) - VW'(1);
   assign per_f_ovf = (per_ff != '0) && rtp_pkg::pow10_ovf(VW'(per_ff));

   // multiplier operand selection
   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      mul_c   = '0;
      pow_ovf = 1'b0;
      unique case (cmd.mul_op)
         rtp_pkg::MUL_FIRST: begin
            mul_a = first_ff;
            mul_c = second_ff;
            if (cmd.form == rtp_pkg::FORM_MIXED) begin
               mul_b = third_ff;
            end else begin
               mul_b   = rtp_pkg::pow10_val(VW'(frac_ff));
               pow_ovf = rtp_pkg::pow10_ovf(VW'(frac_ff));
            end
         end
         rtp_pkg::MUL_PER_NUM: begin
            mul_a   = num_ff;
            mul_b   = per_f;
            mul_c   = third_ff;
            pow_ovf = per_f_ovf;
         end
         rtp_pkg::MUL_PER_DEN: begin
            mul_a = den_ff;
            mul_b = per_f;
         end
         rtp_pkg::MUL_EXP: begin
            mul_a   = cmd.exp_neg ? den_ff : num_ff;
            mul_b   = rtp_pkg::pow10_val(third_ff);
            pow_ovf = rtp_pkg::pow10_ovf(third_ff);
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   rtp_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (cmd.mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .c     (mul_c),
      .busy  (mul_busy),
      .done  (mul_done),
      .prod  (mul_prod),
      .ovf   (mul_ovf)
   );

   assign stat.mul_busy = mul_busy;
   assign stat.mul_done = mul_done;

   // result assembly
   always_comb begin
      unique case (cmd.form)
         rtp_pkg::FORM_INTEGER: begin
            cap_mag = first_ff;
            cap_den = VW'(1);
         end
         rtp_pkg::FORM_FRACTION: begin
            cap_mag = first_ff;
            cap_den = second_ff;
         end
         default: begin
            cap_mag = num_ff;
            cap_den = den_ff;
         end
      endcase
      priority if (cmd.form == rtp_pkg::FORM_NONE) cap_stat = rtp_pkg::STAT_MALFORMED;
      else if (ovf_ff) cap_stat = rtp_pkg::STAT_OVERFLOW;
      else if (cmd.form == rtp_pkg::FORM_MIXED && second_ff > third_ff)
         cap_stat = rtp_pkg::STAT_MIXED;
      else cap_stat = rtp_pkg::STAT_OK;
      if (cap_stat != rtp_pkg::STAT_OK) begin
         cap_mag = '0;
         cap_den = VW'(1);
      end
      if (cap_den == '0) cap_den = VW'(1);
   end

   // register next values
   always_comb begin
      first_in  = first_ff;
      second_in = second_ff;
      third_in  = third_ff;
      frac_in   = frac_ff;
      per_in    = per_ff;
      ovf_in    = ovf_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      onum_in   = onum_ff;
      oden_in   = oden_ff;
      oform_in  = oform_ff;
      ostat_in  = ostat_ff;
      if (cmd.capture) begin
         onum_in   = cmd.negative ? 64'd0 - 64'(cap_mag) : 64'(cap_mag);
         oden_in   = 63'(cap_den);
         oform_in  = cmd.form;
         ostat_in  = cap_stat;
         first_in  = '0;
         second_in = '0;
         third_in  = '0;
         frac_in   = '0;
         per_in    = '0;
         ovf_in    = 1'b0;
      end else begin
         if (cmd.acc_sel != rtp_pkg::ACC_NONE) begin
            if (acc_ovf) begin
               ovf_in = 1'b1;
            end else begin
               unique case (cmd.acc_sel)
                  rtp_pkg::ACC_FIRST:  first_in  = acc_ten[VW-1:0];
                  rtp_pkg::ACC_SECOND: second_in = acc_ten[VW-1:0];
                  rtp_pkg::ACC_THIRD:  third_in  = acc_ten[VW-1:0];
                  default:             first_in  = first_ff;
               endcase
            end
         end
         if (cmd.inc_frac && frac_ff != rtp_pkg::DCNT_MAX) frac_in = frac_ff + 1'b1;
         if (cmd.inc_per && per_ff != rtp_pkg::DCNT_MAX) per_in = per_ff + 1'b1;
         if (cmd.mul_start && pow_ovf) ovf_in = 1'b1;
         if (mul_done) begin
            if (mul_ovf) ovf_in = 1'b1;
            unique case (cmd.mul_op)
               rtp_pkg::MUL_FIRST: begin
                  num_in = mul_prod;
                  den_in = mul_b;
               end
               rtp_pkg::MUL_PER_NUM: num_in = mul_prod;
               rtp_pkg::MUL_PER_DEN: den_in = mul_prod;
               rtp_pkg::MUL_EXP: begin
                  if (cmd.exp_neg) den_in = mul_prod;
                  else num_in = mul_prod;
               end
               default: num_in = num_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff  <= '0;
         second_ff <= '0;
         third_ff  <= '0;
         frac_ff   <= '0;
         per_ff    <= '0;
         ovf_ff    <= 1'b0;
      end else begin
         first_ff  <= first_in;
         second_ff <= second_in;
         third_ff  <= third_in;
         frac_ff   <= frac_in;
         per_ff    <= per_in;
         ovf_ff    <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff   <= num_in;
      den_ff   <= den_in;
      onum_ff  <= onum_in;
      oden_ff  <= oden_in;
      oform_ff <= oform_in;
      ostat_ff <= ostat_in;
   end

   assign rsp_num    = onum_ff;
   assign rsp_den    = oden_ff;
   assign rsp_form   = oform_ff;
   assign rsp_status = ostat_ff;

endmodule

/* rtl/rtp_ctrl.sv */
// Controller: character parsing state machine and finishing sequencer.
`timescale 1ns / 1ps
module rtp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_ch,
   input  logic                 req_last,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output rtp_pkg::dp_cmd_type  cmd,
   input  rtp_pkg::dp_stat_type stat
);
   rtp_pkg::state_type  state_ff, state_in;
   rtp_pkg::form_type   form_ff, form_in;
   logic                neg_ff, neg_in;
   logic                expneg_ff, expneg_in;
   logic                valid_ff, valid_in;

   logic                text_phase, accept, capture, is_dig;
   rtp_pkg::state_type  int_phase, dec_phase;
   rtp_pkg::acc_sel_type int_acc, dec_acc;
   logic                dec_frac, dec_per, dec_neg, dec_expneg;
   rtp_pkg::form_type   end_form;

   assign text_phase = (state_ff < rtp_pkg::ST_MUL1);
   assign accept     = req_tvalid && text_phase;
   assign capture    = (state_ff == rtp_pkg::ST_CAP) && (!valid_ff || rsp_tready);
   assign is_dig     = (req_ch >= rtp_pkg::CH_ZERO) && (req_ch <= rtp_pkg::CH_NINE);

   // character decode for the integer part
   always_comb begin
      int_acc = rtp_pkg::ACC_NONE;
      priority if (is_dig) begin
         int_phase = rtp_pkg::ST_INT;
         int_acc   = rtp_pkg::ACC_FIRST;
      end
      else if (req_ch == rtp_pkg::CH_SLASH) int_phase = rtp_pkg::ST_DEN;
      else if (req_ch == rtp_pkg::CH_PLUS)  int_phase = rtp_pkg::ST_MIXN;
      else if (req_ch == rtp_pkg::CH_DOT)   int_phase = rtp_pkg::ST_FRACT;
      else int_phase = rtp_pkg::ST_ERR;
   end

   // character decode for every text phase
   always_comb begin
      dec_phase  = rtp_pkg::ST_ERR;
      dec_acc    = rtp_pkg::ACC_NONE;
      dec_frac   = 1'b0;
      dec_per    = 1'b0;
      dec_neg    = 1'b0;
      dec_expneg = 1'b0;
      unique case (state_ff)
         rtp_pkg::ST_SKIP: begin
            priority if (req_ch <= rtp_pkg::CH_SPACE) dec_phase = rtp_pkg::ST_SKIP;
            else if (req_ch == rtp_pkg::CH_MINUS) begin
               dec_neg   = 1'b1;
               dec_phase = rtp_pkg::ST_INT;
            end else begin
               dec_phase = int_phase;
               dec_acc   = int_acc;
            end
         end
         rtp_pkg::ST_INT: begin
            dec_phase = int_phase;
            dec_acc   = int_acc;
         end
         rtp_pkg::ST_DEN: begin
            if (is_dig) begin
               dec_phase = rtp_pkg::ST_DEN;
               dec_acc   = rtp_pkg::ACC_SECOND;
            end
         end
         rtp_pkg::ST_MIXD: begin
            if (is_dig) begin
               dec_phase = rtp_pkg::ST_MIXD;
               dec_acc   = rtp_pkg::ACC_THIRD;
            end
         end
         rtp_pkg::ST_MIXN: begin
            priority if (is_dig) begin
               dec_phase = rtp_pkg::ST_MIXN;
               dec_acc   = rtp_pkg::ACC_SECOND;
            end
            else if (req_ch == rtp_pkg::CH_SLASH) dec_phase = rtp_pkg::ST_MIXD;
            else dec_phase = rtp_pkg::ST_ERR;
         end
         rtp_pkg::ST_FRACT: begin
            priority if (is_dig) begin
               dec_phase = rtp_pkg::ST_FRACT;
               dec_acc   = rtp_pkg::ACC_SECOND;
               dec_frac  = 1'b1;
            end
            else if (req_ch == rtp_pkg::CH_LPAR) dec_phase = rtp_pkg::ST_PER;
            else if (req_ch == rtp_pkg::CH_E_LO || req_ch == rtp_pkg::CH_E_UP)
               dec_phase = rtp_pkg::ST_EXPS;
            else dec_phase = rtp_pkg::ST_ERR;
         end
         rtp_pkg::ST_PER: begin
            priority if (is_dig) begin
               dec_phase = rtp_pkg::ST_PER;
               dec_acc   = rtp_pkg::ACC_THIRD;
               dec_per   = 1'b1;
            end
            else if (req_ch == rtp_pkg::CH_RPAR) dec_phase = rtp_pkg::ST_PEREND;
            else dec_phase = rtp_pkg::ST_ERR;
         end
         rtp_pkg::ST_EXPS: begin
            priority if (req_ch == rtp_pkg::CH_PLUS) dec_phase = rtp_pkg::ST_EXPD;
            else if (req_ch == rtp_pkg::CH_MINUS) begin
               dec_expneg = 1'b1;
               dec_phase  = rtp_pkg::ST_EXPD;
            end else if (is_dig) begin
               dec_acc   = rtp_pkg::ACC_THIRD;
               dec_phase = rtp_pkg::ST_EXPD;
            end
            else dec_phase = rtp_pkg::ST_ERR;
         end
         rtp_pkg::ST_EXPD: begin
            if (is_dig) begin
               dec_phase = rtp_pkg::ST_EXPD;
               dec_acc   = rtp_pkg::ACC_THIRD;
            end
         end
         default: dec_phase = rtp_pkg::ST_ERR;
      endcase
   end

   // form recognized by the phase the text ends in
   always_comb begin
      unique case (dec_phase)
         rtp_pkg::ST_SKIP, rtp_pkg::ST_INT: end_form = rtp_pkg::FORM_INTEGER;
         rtp_pkg::ST_DEN:                   end_form = rtp_pkg::FORM_FRACTION;
         rtp_pkg::ST_MIXD:                  end_form = rtp_pkg::FORM_MIXED;
         rtp_pkg::ST_FRACT:                 end_form = rtp_pkg::FORM_DECIMAL;
         rtp_pkg::ST_PEREND:                end_form = rtp_pkg::FORM_PERIODIC;
         rtp_pkg::ST_EXPS, rtp_pkg::ST_EXPD: end_form = rtp_pkg::FORM_EXPONENT;
         default:                           end_form = rtp_pkg::FORM_NONE;
      endcase
   end

   // next state
   always_comb begin
      state_in  = state_ff;
      form_in   = form_ff;
      neg_in    = neg_ff;
      expneg_in = expneg_ff;
      valid_in  = valid_ff;
      if (rsp_tready) valid_in = 1'b0;
      if (text_phase) begin
         if (accept) begin
            if (dec_neg) neg_in = 1'b1;
            if (dec_expneg) expneg_in = 1'b1;
            if (req_last) begin
               form_in = end_form;
               unique case (end_form)
                  rtp_pkg::FORM_NONE, rtp_pkg::FORM_INTEGER, rtp_pkg::FORM_FRACTION:
                     state_in = rtp_pkg::ST_CAP;
                  default: state_in = rtp_pkg::ST_MUL1;
               endcase
            end else begin
               state_in = dec_phase;
            end
         end
      end else begin
         unique case (state_ff)
            rtp_pkg::ST_MUL1: begin
               if (stat.mul_done) begin
                  unique case (form_ff)
                     rtp_pkg::FORM_PERIODIC: state_in = rtp_pkg::ST_MUL2;
                     rtp_pkg::FORM_EXPONENT: state_in = rtp_pkg::ST_MUL4;
                     default:                state_in = rtp_pkg::ST_CAP;
                  endcase
               end
            end
            rtp_pkg::ST_MUL2: if (stat.mul_done) state_in = rtp_pkg::ST_MUL3;
            rtp_pkg::ST_MUL3: if (stat.mul_done) state_in = rtp_pkg::ST_CAP;
            rtp_pkg::ST_MUL4: if (stat.mul_done) state_in = rtp_pkg::ST_CAP;
            rtp_pkg::ST_CAP: begin
               if (capture) begin
                  state_in  = rtp_pkg::ST_SKIP;
                  neg_in    = 1'b0;
                  expneg_in = 1'b0;
                  valid_in  = 1'b1;
               end
            end
            default: state_in = rtp_pkg::ST_SKIP;
         endcase
      end
   end

   // datapath commands
   always_comb begin
      cmd.acc_sel  = accept ? dec_acc : rtp_pkg::ACC_NONE;
      cmd.inc_frac = accept && dec_frac;
      cmd.inc_per  = accept && dec_per;
      cmd.exp_neg  = expneg_ff;
      cmd.capture  = capture;
      cmd.form     = form_ff;
      cmd.negative = neg_ff;
      unique case (state_ff)
         rtp_pkg::ST_MUL1: cmd.mul_op = rtp_pkg::MUL_FIRST;
         rtp_pkg::ST_MUL2: cmd.mul_op = rtp_pkg::MUL_PER_NUM;
         rtp_pkg::ST_MUL3: cmd.mul_op = rtp_pkg::MUL_PER_DEN;
         rtp_pkg::ST_MUL4: cmd.mul_op = rtp_pkg::MUL_EXP;
         default:          cmd.mul_op = rtp_pkg::MUL_NONE;
      endcase
      cmd.mul_start = (cmd.mul_op != rtp_pkg::MUL_NONE) && !stat.mul_busy && !stat.mul_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= rtp_pkg::ST_SKIP;
         form_ff   <= rtp_pkg::FORM_NONE;
         neg_ff    <= 1'b0;
         expneg_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         form_ff   <= form_in;
         neg_ff    <= neg_in;
         expneg_ff <= expneg_in;
         valid_ff  <= valid_in;
      end
   end

   assign req_tready = text_phase;
   assign rsp_tvalid = valid_ff;

endmodule

/* tb/tb_rational_text_parser.sv */
// Testbench for the rational text parser: directed and random texts checked against a predictor.
`timescale 1ns / 1ps
module tb_rational_text_parser;

   localparam logic [62:0] MAG_MAX = '1;
   localparam int IDLE_LIMIT = 5000;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;   // [7:0] ch
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;   // [63:0] numerator, [126:64] denominator, [127] zero
   logic [4:0]   rsp_tuser;   // [2:0] form, [4:3] status

   typedef struct packed {
      logic [63:0]         num;
      logic [62:0]         den;
      rtp_pkg::form_type   form;
      rtp_pkg::status_type status;
   } fraction_type;

   fraction_type parsed_q[$];
   int  fail_count;
   int  idle_cycles;
   bit  rsp_hold;
   int  hold_cycles;
   int  rsp_wait;

   rational_text_parser u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0; #5;
      clock = 1'b1; #5;
   end

   // ---------------- parser predictor ----------------
   rtp_pkg::state_type p_phase;
   logic         p_neg, p_exp_neg, p_ovf, p_bad;
   logic [63:0]  p_first, p_second, p_third;
   int unsigned  p_fdig, p_pdig;

   function automatic void parse_clear();
      p_phase = rtp_pkg::ST_SKIP; p_neg = 0; p_exp_neg = 0; p_ovf = 0; p_bad = 0;
      p_first = 0; p_second = 0; p_third = 0; p_fdig = 0; p_pdig = 0;
   endfunction

   function automatic bit is_dig(logic [7:0] c);
      return c >= rtp_pkg::CH_ZERO && c <= rtp_pkg::CH_NINE;
   endfunction

   function automatic logic [63:0] add_digit(logic [63:0] v, logic [7:0] c);
      logic [63:0] d;
      d = 64'(c - rtp_pkg::CH_ZERO);
      if (v > (64'(MAG_MAX) - d) / 10) begin
         p_ovf = 1; return v;
      end
      return v * 10 + d;
   endfunction

   function automatic logic [63:0] mul_lim(logic [63:0] a, logic [63:0] b);
      if (a != 0 && b > 64'(MAG_MAX) / a) begin
         p_ovf = 1; return 0;
      end
      return a * b;
   endfunction

   function automatic logic [63:0] add_lim(logic [63:0] a, logic [63:0] b);
      if (a > 64'(MAG_MAX) - b) begin
         p_ovf = 1; return 0;
      end
      return a + b;
   endfunction

   function automatic logic [63:0] ten_pow(logic [63:0] n);
      logic [63:0] r;
      r = 1;
      if (n > 19) begin
         p_ovf = 1; return 0;
      end
      for (int i = 0; i < n; i++) r = mul_lim(r, 10);
      return r;
   endfunction

   function automatic void take_ch(logic [7:0] c);
      case (p_phase)
         rtp_pkg::ST_SKIP: begin
            if (c <= rtp_pkg::CH_SPACE) return;
            if (c == rtp_pkg::CH_MINUS) begin
               p_neg = 1; p_phase = rtp_pkg::ST_INT; return;
            end
            p_phase = rtp_pkg::ST_INT;
            take_ch(c);
         end
         rtp_pkg::ST_INT: begin
            if (is_dig(c)) p_first = add_digit(p_first, c);
            else if (c == rtp_pkg::CH_SLASH) p_phase = rtp_pkg::ST_DEN;
            else if (c == rtp_pkg::CH_PLUS) p_phase = rtp_pkg::ST_MIXN;
            else if (c == rtp_pkg::CH_DOT) p_phase = rtp_pkg::ST_FRACT;
            else p_phase = rtp_pkg::ST_ERR;
         end
         rtp_pkg::ST_DEN: begin
            if (is_dig(c)) p_second = add_digit(p_second, c);
            else p_phase = rtp_pkg::ST_ERR;
         end
         rtp_pkg::ST_MIXD: begin
            if (is_dig(c)) p_third = add_digit(p_third, c);
            else p_phase = rtp_pkg::ST_ERR;
         end
         rtp_pkg::ST_MIXN: begin
            if (is_dig(c)) p_second = add_digit(p_second, c);
            else if (c == rtp_pkg::CH_SLASH) p_phase = rtp_pkg::ST_MIXD;
            else p_phase = rtp_pkg::ST_ERR;
         end
         rtp_pkg::ST_FRACT: begin
            if (is_dig(c)) begin
               p_second = add_digit(p_second, c);
               if (p_fdig < 31) p_fdig++;
            end else if (c == rtp_pkg::CH_LPAR) p_phase = rtp_pkg::ST_PER;
            else if (c == rtp_pkg::CH_E_LO || c == rtp_pkg::CH_E_UP)
               p_phase = rtp_pkg::ST_EXPS;
            else p_phase = rtp_pkg::ST_ERR;
         end
         rtp_pkg::ST_PER: begin
            if (is_dig(c)) begin
               p_third = add_digit(p_third, c);
               if (p_pdig < 31) p_pdig++;
            end else if (c == rtp_pkg::CH_RPAR) p_phase = rtp_pkg::ST_PEREND;
            else p_phase = rtp_pkg::ST_ERR;
         end
         rtp_pkg::ST_EXPS: begin
            if (c == rtp_pkg::CH_PLUS) p_phase = rtp_pkg::ST_EXPD;
            else if (c == rtp_pkg::CH_MINUS) begin
               p_exp_neg = 1; p_phase = rtp_pkg::ST_EXPD;
            end else if (is_dig(c)) begin
               p_third = add_digit(p_third, c); p_phase = rtp_pkg::ST_EXPD;
            end else p_phase = rtp_pkg::ST_ERR;
         end
         rtp_pkg::ST_EXPD: begin
            if (is_dig(c)) p_third = add_digit(p_third, c);
            else p_phase = rtp_pkg::ST_ERR;
         end
         default: p_phase = rtp_pkg::ST_ERR;
      endcase
   endfunction

   // feed one character; on the final one push the expected fraction
   function automatic void predict_char(logic [7:0] c, logic last);
      logic [63:0] num, den, sc, f;
      rtp_pkg::form_type   fm;
      rtp_pkg::status_type st;
      num = 0; den = 1; fm = rtp_pkg::FORM_NONE; st = rtp_pkg::STAT_OK;
      take_ch(c);
      if (!last) return;
      case (p_phase)
         rtp_pkg::ST_SKIP, rtp_pkg::ST_INT: begin
            fm = rtp_pkg::FORM_INTEGER; num = p_first;
         end
         rtp_pkg::ST_DEN: begin
            fm = rtp_pkg::FORM_FRACTION; num = p_first; den = p_second;
         end
         rtp_pkg::ST_MIXD: begin
            fm = rtp_pkg::FORM_MIXED;
            if (p_second > p_third) st = rtp_pkg::STAT_MIXED;
            num = add_lim(mul_lim(p_first, p_third), p_second);
            den = p_third;
         end
         rtp_pkg::ST_FRACT, rtp_pkg::ST_PEREND, rtp_pkg::ST_EXPS, rtp_pkg::ST_EXPD: begin
            sc = ten_pow(64'(p_fdig));
            num = add_lim(mul_lim(p_first, sc), p_second);
            den = sc;
            if (p_phase == rtp_pkg::ST_FRACT) fm = rtp_pkg::FORM_DECIMAL;
            else if (p_phase == rtp_pkg::ST_PEREND) begin
               fm = rtp_pkg::FORM_PERIODIC;
               f = 1;
               if (p_pdig != 0) f = ten_pow(64'(p_pdig)) - 1;
               num = add_lim(mul_lim(num, f), p_third);
               den = mul_lim(den, f);
            end else begin
               fm = rtp_pkg::FORM_EXPONENT;
               sc = ten_pow(p_third);
               if (p_exp_neg) den = mul_lim(den, sc);
               else num = mul_lim(num, sc);
            end
         end
         default: p_bad = 1;
      endcase
      if (p_bad) begin
         fm = rtp_pkg::FORM_NONE; st = rtp_pkg::STAT_MALFORMED;
      end else if (p_ovf) st = rtp_pkg::STAT_OVERFLOW;
      if (st != rtp_pkg::STAT_OK) begin
         num = 0; den = 1;
      end
      if (den == 0) den = 1;
      if (p_neg) num = 0 - num;
      parsed_q.push_back('{num, den[62:0], fm, st});
      parse_clear();
   endfunction

   // ---------------- driver ----------------
   task automatic send_char(logic [7:0] c, logic last);
      int gap;
      gap = $urandom_range(0, 16);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_char(c, last);
   endtask

   // drop the request once a run of texts is over
   task automatic idle_req();
      req_tvalid <= 1'b0;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
   endtask

   task automatic wait_drained();
      while (parsed_q.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // ---------------- result checker ----------------
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         fraction_type got, exp_r;
         got = '{rsp_tdata[63:0], rsp_tdata[126:64], rtp_pkg::form_type'(rsp_tuser[2:0]),
                 rtp_pkg::status_type'(rsp_tuser[4:3])};
         if (parsed_q.size() == 0) begin
            $display("%0t unexpected fraction num=%0d den=%0d", $time,
                     $signed(got.num), got.den);
            fail_count++;
         end else begin
            exp_r = parsed_q.pop_front();
            if (got.num !== exp_r.num) begin
               $display("%0t numerator exp %0d got %0d", $time,
                        $signed(exp_r.num), $signed(got.num));
               fail_count++;
            end
            if (got.den !== exp_r.den) begin
               $display("%0t denominator exp %0d got %0d", $time, exp_r.den, got.den);
               fail_count++;
            end
            if (got.form !== exp_r.form) begin
               $display("%0t form exp %0d got %0d", $time, exp_r.form, got.form);
               fail_count++;
            end
            if (got.status !== exp_r.status) begin
               $display("%0t status exp %0d got %0d", $time, exp_r.status, got.status);
               fail_count++;
            end
         end
      end
   end

   // receiver stalls: random per result, or a long hold when requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready  <= 1'b0;
         hold_cycles <= 0;
      end else if (rsp_hold) begin
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         rsp_tready  <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else if (rsp_tvalid && rsp_tready) begin
         rsp_wait = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
         rsp_tready  <= (rsp_wait == 0);
         hold_cycles <= (rsp_wait == 0) ? 0 : rsp_wait - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // ---------------- random text builders ----------------
   function automatic string digits(int maxn);
      string s;
      int n;
      s = "";
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 21) : $urandom_range(0, maxn);
      for (int i = 0; i < n; i++)
         s = {s, string'(8'(rtp_pkg::CH_ZERO + $urandom_range(0, 9)))};
      return s;
   endfunction

   function automatic string random_text();
      string s, body;
      int k;
      s = "";
      k = $urandom_range(0, 3);
      for (int i = 0; i < k; i++) s = {s, string'(8'($urandom_range(0, 32)))};
      if ($urandom_range(0, 1)) s = {s, "-"};
      case ($urandom_range(0, 7))
         0: body = digits(8);
         1: body = {digits(8), "/", digits(6)};
         2: body = {digits(4), "+", digits(3), "/", digits(3)};
         3: body = {digits(6), ".", digits(5)};
         4: body = {digits(4), ".", digits(3), "(", digits(3), ")"};
         5: body = {digits(4), ".", digits(3), ($urandom_range(0, 1) ? "e" : "E"),
                    ($urandom_range(0, 2) == 0 ? "" : ($urandom_range(0, 1) ? "+" : "-")),
                    digits(2)};
         6: begin
            // broken sequence: random printable and binary noise
            body = "";
            k = $urandom_range(1, 6);
            for (int i = 0; i < k; i++) body = {body, string'(8'($urandom_range(1, 255)))};
         end
         default: begin
            body = {digits(4), ".", digits(2)};
            body = {body, string'(8'($urandom_range(33, 126)))};
         end
      endcase
      s = {s, body};
      if (s.len() == 0) s = "0";
      return s;
   endfunction

   // ---------------- tests ----------------
   task automatic test_directed();
      send_text("0");
      send_text("  -42");
      send_text(" ");
      send_text("-");
      send_text("9223372036854775807");
      send_text("9223372036854775808");
      send_text("3/4");
      send_text("-5/0");
      send_text("1+2/3");
      send_text("1+5/3");
      send_text("1+2");
      send_text("3.14");
      send_text("0.1(6)");
      send_text("1.(3");
      send_text("2.5()");
      send_text("1.5e3");
      send_text("-1.5E-2");
      send_text("1.0e");
      send_text("1.0e25");
      send_text("- 1");
      send_text("1/2.5");
      send_text("1.2(3)4");
      send_text("0.00000000000000000001");
      send_text({8'h00, 8'hff, "7"});
      idle_req();
      wait_drained();
   endtask

   task automatic test_random(int n);
      int sent;
      sent = 0;
      while (sent < n) begin
         string s;
         s = random_text();
         send_text(s);
         sent += s.len();
      end
      idle_req();
   endtask

   task automatic test_backpressure();
      rsp_hold = 1;
      fork
         begin
            repeat (300) @(posedge clock);
            rsp_hold = 0;
         end
         test_random(60);
      join
      wait_drained();
   endtask

   initial begin
      fail_count = 0;
      rsp_hold   = 0;
      parse_clear();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(250);
      wait_drained();
      test_backpressure();
      test_random(250);
      wait_drained();
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

/* sim.f */
rtl/rtp_pkg.sv
rtl/rtp_mul.sv
rtl/rtp_dp.sv
rtl/rtp_ctrl.sv
rtl/rational_text_parser.sv
tb/tb_rational_text_parser.sv
